/* hw/rtl/typed_entity_table_nearest_search_assert.svh */
// Assertion macros for the entity table block.
`ifndef TYPED_ENTITY_TABLE_NEAREST_SEARCH_ASSERT_SVH
`define TYPED_ENTITY_TABLE_NEAREST_SEARCH_ASSERT_SVH
// Implication checked at every edge outside reset.
`define TETS_ASSERT_IMP(label, clk, rst_n, a, c) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
		else $error("assertion failed");
// Next-cycle implication.
`define TETS_ASSERT_NXT(label, clk, rst_n, a, c) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
		else $error("assertion failed");
`endif

/* hw/rtl/tets_pkg.sv */
// ----------------------------------------------------------------------------
// tets_pkg
// Shared types and codes of the typed entity table.
// ----------------------------------------------------------------------------
package tets_pkg;
	localparam int CoordW = 24;
	localparam int DistW  = 26;
	localparam logic [DistW-1:0] DIST_NONE = '1;

	typedef enum logic [2:0] {
		MODE_ADD = 3'd0, MODE_REMOVE = 3'd1, MODE_MOVE = 3'd2,
		MODE_FIND = 3'd3, MODE_CLEAR = 3'd4
	} mode_e_t;

	typedef enum logic [1:0] {
		ST_DONE = 2'd0, ST_NO_TYPE = 2'd1, ST_NONE = 2'd2, ST_FULL = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		FSM_IDLE, FSM_SCAN, FSM_SHIFT, FSM_WRITE, FSM_OUT
	} fsm_t;

	typedef struct packed {
		logic [2:0]        mode;
		logic [3:0]        res_type;
		logic [31:0]       entity_id;
		logic signed [23:0] pos_x, pos_y, pos_z;
		logic signed [23:0] new_x, new_y, new_z;
		logic              allow_same;
	} req_t;

	typedef struct packed {
		logic [1:0]         status;
		logic [31:0]        near_entity;
		logic signed [23:0] near_x, near_y, near_z;
		logic [25:0]        distance;
		logic [6:0]         type_count;
	} rsp_t;

	typedef struct packed {
		logic [3:0]         kind;
		logic [31:0]        ent;
		logic signed [23:0] px, py, pz;
	} entry_t;

	function automatic logic [24:0] absdiff(logic signed [23:0] a, logic signed [23:0] b);
		logic signed [24:0] d;
		d = 25'(a) - 25'(b);
		return d[24] ? 25'(-d) : 25'(d);
	endfunction
endpackage

/* hw/rtl/tets_if.sv */
// ----------------------------------------------------------------------------
// tets_req_if / tets_rsp_if / tets_cfg_if
// Valid/ready channels of the block.
// ----------------------------------------------------------------------------
interface tets_req_if;
	import tets_pkg::*;
	logic valid, ready;
	req_t data;
	modport source(output valid, data, input ready);
	modport sink(input valid, data, output ready);
endinterface

interface tets_rsp_if;
	import tets_pkg::*;
	logic valid, ready;
	rsp_t data;
	modport source(output valid, data, input ready);
	modport sink(input valid, data, output ready);
endinterface

interface tets_cfg_if;
	logic valid, ready;
	logic [7:0] data;
	modport source(output valid, data, input ready);
	modport sink(input valid, data, output ready);
endinterface

/* hw/rtl/tets_mem.sv */
// ----------------------------------------------------------------------------
// tets_mem
// Entry memory, one write and one registered read port.
// ----------------------------------------------------------------------------
module tets_mem #(
	parameter int Depth = 64,
	parameter int AW    = 6
) (
	input  logic                  clk,
	input  logic                  we,
	input  logic [AW-1:0]         waddr,
	input  tets_pkg::entry_t      wdata,
	input  logic [AW-1:0]         raddr,
	output tets_pkg::entry_t      rdata
);
	import tets_pkg::*;
	entry_t mem [Depth];
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

/* hw/rtl/typed_entity_table_nearest_search.sv */
// ----------------------------------------------------------------------------
// typed_entity_table_nearest_search
// Typed entity table with nearest search. Entries (type, entity, x/y/z Q15.8)
// live in one synchronous memory; one item is taken at a time. Add, clear,
// bad-type and unused-mode items finish without a scan. Remove, move and find
// scan the filled part of the memory one entry per cycle through its single
// read port; remove then closes the gap one entry per cycle. Per-type flags
// and counts sit in flip-flops. match_tolerance is written through cfg; the
// user must write it only while idle, as the block itself does not enforce it.
// ----------------------------------------------------------------------------
module typed_entity_table_nearest_search #(
	parameter int TABLE_ENTRIES = 64,
	parameter int TYPE_COUNT    = 16
) (
	input logic clk,
	input logic arst_n,
	tets_req_if.sink   req,
	tets_rsp_if.source rsp,
	tets_cfg_if.sink   cfg
);
	import tets_pkg::*;
	localparam int AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam int CW = $clog2(TABLE_ENTRIES + 1);
	localparam int TW = (TYPE_COUNT > 1) ? $clog2(TYPE_COUNT) : 1;

	fsm_t state_q, state_d;
	req_t r_q;
	logic [7:0] tol_q;
	logic [CW-1:0] fill_q;
	logic [TYPE_COUNT-1:0] present_q;
	logic [CW-1:0] cnt_q [TYPE_COUNT];
	logic [CW-1:0] idx_q;       // next read address
	logic [CW-1:0] chk_q;       // address of entry now on rdata
	logic rd_vld_q;
	logic hit_q;
	logic [DistW:0] best_q;
	entry_t best_e_q;
	rsp_t out_q, out_d;
	logic out_vld_q;

	logic we;
	logic [AW-1:0] waddr, raddr;
	entry_t wdata, rdata;

	tets_mem #(.Depth(TABLE_ENTRIES), .AW(AW)) u_mem (
		.clk, .we, .waddr, .wdata, .raddr, .rdata
	);

	logic valid_t;
	logic [TW-1:0] tix;
	assign valid_t = 32'(r_q.res_type) < TYPE_COUNT;
	assign tix = valid_t ? TW'(r_q.res_type) : '0;

	// compare of the entry on the read port
	logic kind_eq, match, qual;
	logic [DistW:0] dist_sum;
	always_comb begin
		kind_eq = 32'(rdata.kind) == 32'(r_q.res_type);
		match = kind_eq && rdata.ent == r_q.entity_id
			&& absdiff(rdata.px, r_q.pos_x) <= 25'(tol_q)
			&& absdiff(rdata.py, r_q.pos_y) <= 25'(tol_q)
			&& absdiff(rdata.pz, r_q.pos_z) <= 25'(tol_q);
		dist_sum = 27'(absdiff(rdata.px, r_q.pos_x)) + 27'(absdiff(rdata.py, r_q.pos_y))
			+ 27'(absdiff(rdata.pz, r_q.pos_z));
		// strict compare keeps the earliest entry on a tie
		qual = kind_eq && dist_sum < best_q && (r_q.allow_same || dist_sum != '0);
	end

	assign req.ready = state_q == FSM_IDLE && !out_vld_q;
	assign cfg.ready = 1'b1;
	assign rsp.valid = out_vld_q;
	assign rsp.data  = out_q;
	assign raddr = idx_q[AW-1:0];

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= FSM_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// stop at the first match for remove/move, at the last filled entry otherwise
	logic scan_end;
	assign scan_end = rd_vld_q
		&& ((r_q.mode != MODE_FIND && match) || chk_q + 1'b1 >= fill_q);

	// next state and memory write
	always_comb begin
		state_d = state_q;
		we = 1'b0;
		waddr = fill_q[AW-1:0];
		wdata = '{kind: r_q.res_type, ent: r_q.entity_id,
			px: r_q.pos_x, py: r_q.pos_y, pz: r_q.pos_z};
		case (state_q)
			FSM_IDLE: begin
				if (req.valid && req.ready) begin
					state_d = FSM_WRITE;
				end
			end
			FSM_WRITE: begin
				// decide: simple items finish here, others scan
				if (valid_t && present_q[tix] && fill_q != '0
						&& (r_q.mode == MODE_REMOVE || r_q.mode == MODE_MOVE
						|| r_q.mode == MODE_FIND)) begin
					state_d = FSM_SCAN;
				end else begin
					state_d = FSM_OUT;
					we = r_q.mode == MODE_ADD && valid_t && fill_q < CW'(TABLE_ENTRIES);
				end
			end
			FSM_SCAN: begin
				if (scan_end) begin
					if (r_q.mode == MODE_MOVE && match) begin
						we = 1'b1;
						waddr = chk_q[AW-1:0];
						wdata = '{kind: rdata.kind, ent: rdata.ent,
							px: r_q.new_x, py: r_q.new_y, pz: r_q.new_z};
					end
					state_d = (r_q.mode == MODE_REMOVE && match) ? FSM_SHIFT : FSM_OUT;
				end
			end
			FSM_SHIFT: begin
				// rdata holds entry idx-1; write it one place down
				if (rd_vld_q) begin
					we = 1'b1;
					waddr = AW'(chk_q - 1'b1);
					wdata = rdata;
				end
				// finish after the last entry moved, or at once when the match was last
				if (!rd_vld_q || chk_q + 1'b1 >= fill_q) begin
					state_d = FSM_OUT;
				end
			end
			FSM_OUT: state_d = FSM_IDLE;
			default: state_d = FSM_IDLE;
		endcase
	end

	// datapath
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			r_q <= '0;
			tol_q <= 8'd26;
			fill_q <= '0;
			present_q <= '0;
			for (int i = 0; i < TYPE_COUNT; i++) cnt_q[i] <= '0;
			out_vld_q <= 1'b0;
			rd_vld_q <= 1'b0;
			idx_q <= '0;
			chk_q <= '0;
			hit_q <= 1'b0;
			best_q <= '0;
			best_e_q <= '0;
		end else begin
			if (cfg.valid) tol_q <= cfg.data;
			if (rsp.valid && rsp.ready) out_vld_q <= 1'b0;
			case (state_q)
				FSM_IDLE: begin
					if (req.valid && req.ready) r_q <= req.data;
					idx_q <= '0;
					rd_vld_q <= 1'b0;
					hit_q <= 1'b0;
					best_q <= {1'b1, {DistW{1'b0}}};
				end
				FSM_WRITE: begin
					if (state_d == FSM_SCAN) begin
						idx_q <= CW'(1);
						chk_q <= '0;
						rd_vld_q <= 1'b1;
					end else if (r_q.mode == MODE_CLEAR) begin
						fill_q <= '0;
						present_q <= '0;
						for (int i = 0; i < TYPE_COUNT; i++) cnt_q[i] <= '0;
					end else if (we) begin
						// mark the add as taken; a dropped add answers full
						fill_q <= fill_q + 1'b1;
						present_q[tix] <= 1'b1;
						cnt_q[tix] <= cnt_q[tix] + 1'b1;
						hit_q <= 1'b1;
					end
				end
				FSM_SCAN: begin
					if (qual && r_q.mode == MODE_FIND) begin
						best_q <= dist_sum;
						best_e_q <= rdata;
						hit_q <= 1'b1;
					end
					if (match && r_q.mode != MODE_FIND) begin
						hit_q <= 1'b1;
					end
					if (scan_end) begin
						if (r_q.mode == MODE_REMOVE && match) begin
							// start close-up reading entry match+1
							idx_q <= chk_q + 2'd2;
							chk_q <= chk_q + 1'b1;
							rd_vld_q <= chk_q + 1'b1 < fill_q;
						end else begin
							rd_vld_q <= 1'b0;
						end
					end else begin
						chk_q <= idx_q;
						idx_q <= idx_q + 1'b1;
					end
				end
				FSM_SHIFT: begin
					if (rd_vld_q && chk_q + 1'b1 < fill_q) begin
						chk_q <= idx_q;
						idx_q <= idx_q + 1'b1;
					end else begin
						rd_vld_q <= 1'b0;
					end
					if (state_d == FSM_OUT) begin
						fill_q <= fill_q - 1'b1;
						if (cnt_q[tix] != '0) cnt_q[tix] <= cnt_q[tix] - 1'b1;
					end
				end
				FSM_OUT: begin
					out_vld_q <= 1'b1;
				end
				default: ;
			endcase
		end
	end

	// result word, built in the OUT cycle from settled state
	always_comb begin
		out_d = '0;
		out_d.type_count = valid_t ? 7'(cnt_q[tix]) : 7'd0;
		case (r_q.mode)
			MODE_CLEAR: ;
			MODE_ADD: begin
				if (!valid_t) out_d.status = ST_NO_TYPE;
				else if (!hit_q) out_d.status = ST_FULL;
			end
			MODE_REMOVE, MODE_MOVE: begin
				if (!valid_t || !present_q[tix]) out_d.status = ST_NO_TYPE;
				else if (!hit_q) out_d.status = ST_NONE;
			end
			MODE_FIND: begin
				if (!valid_t || !present_q[tix]) begin
					out_d.status = ST_NO_TYPE;
					out_d.distance = DIST_NONE;
				end else if (!hit_q) begin
					out_d.status = ST_NONE;
					out_d.distance = DIST_NONE;
				end else begin
					out_d.distance = best_q[DistW-1:0];
					out_d.near_entity = best_e_q.ent;
					out_d.near_x = best_e_q.px;
					out_d.near_y = best_e_q.py;
					out_d.near_z = best_e_q.pz;
				end
			end
			default: ;
		endcase
	end

	// hold the result word until the next item is done
	always_ff @(posedge clk) begin
		if (state_q == FSM_OUT) begin
			out_q <= out_d;
		end
	end
endmodule

/* hw/rtl/tets_checker.sv */
// ----------------------------------------------------------------------------
// tets_checker
// Port-level checks of the entity table block.
// ----------------------------------------------------------------------------
`include "typed_entity_table_nearest_search_assert.svh"
module tets_checker (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	input logic req_ready,
	input logic rsp_valid,
	input logic rsp_ready,
	input logic [1:0] rsp_status,
	input logic [25:0] rsp_distance,
	input logic [31:0] rsp_entity
);
	import tets_pkg::*;
	`TETS_ASSERT_IMP(a_no_take_while_out, clk, arst_n, rsp_valid, !req_ready)
	`TETS_ASSERT_NXT(a_busy_after_take, clk, arst_n, req_valid && req_ready, !req_ready)
	`TETS_ASSERT_IMP(a_miss_dist, clk, arst_n,
		rsp_valid && rsp_status == ST_NONE && rsp_distance != '0, rsp_distance == DIST_NONE)
	`TETS_ASSERT_NXT(a_rsp_hold, clk, arst_n, rsp_valid && !rsp_ready, rsp_valid)
	`TETS_ASSERT_IMP(a_miss_entity, clk, arst_n, rsp_valid && rsp_status != ST_DONE, rsp_entity == '0)
endmodule

bind typed_entity_table_nearest_search tets_checker u_chk (
	.clk(clk), .arst_n(arst_n),
	.req_valid(req.valid), .req_ready(req.ready),
	.rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
	.rsp_status(rsp.data.status), .rsp_distance(rsp.data.distance),
	.rsp_entity(rsp.data.near_entity)
);
